FILE: src/pidff_pkg.sv
// Shared types, constants and codes of the four-form PID controller.
package pidff_pkg;

  // Field and datapath widths
  localparam int DATA_W     = 32;
  localparam int GAIN_W     = 32;
  localparam int TIME_W     = 24;
  localparam int FRAC_BITS  = 16;
  localparam int TIME_FRAC  = 16;
  localparam int ACC_W      = 48;
  localparam int TERM_W     = 56;
  localparam int ERR_W      = DATA_W + 1;
  // Widest signed multiplicand: |e0| * dt of the velocity integral
  localparam int OPB_W      = ERR_W + TIME_W + 1;
  localparam int MAG_W      = OPB_W - 1;
  localparam int PROD_W     = MAG_W + GAIN_W;
  // Term sum: accumulator plus four saturated terms
  localparam int SUM_W      = TERM_W + 4;
  // Dividend: gain times a second difference (ERR_W + 2 bits), shifted by TIME_FRAC
  localparam int DVD_W      = GAIN_W + ERR_W + 1 + TIME_FRAC;
  localparam int DVS_W      = TIME_W + FRAC_BITS;
  localparam int MUL_STEPS  = GAIN_W;
  localparam int DIV_STEPS  = DVD_W;
  localparam int CNT_W      = $clog2(DIV_STEPS);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Controller forms
  typedef logic [1:0] mode_t;
  localparam mode_t MODE_POS = 2'd0;
  localparam mode_t MODE_VEL = 2'd1;
  localparam mode_t MODE_PID = 2'd2;
  localparam mode_t MODE_IPD = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_FF = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CLAMP   = 3'd7;

  typedef struct packed {
    logic                     cmd;
    logic signed [DATA_W-1:0] setpoint;
    logic signed [DATA_W-1:0] measured;
    logic [TIME_W-1:0]        step_time;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] drive;
    logic                     clamped;
    logic                     dt_zero;
  } out_t;

  // Terms, in the order the sequencer runs them
  typedef enum logic [2:0] {
    JOB_IPRE,
    JOB_P,
    JOB_I,
    JOB_FF,
    JOB_D
  } job_e;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_LOAD,
    OP_MSTEP,
    OP_DLOAD,
    OP_DSTEP,
    OP_TERM,
    OP_FINISH,
    OP_CLEAR
  } op_e;

  typedef struct packed {
    op_e  op;
    job_e job;
  } dp_cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  dz;
    logic  out_free;
  } dp_status_t;

endpackage

FILE: src/pidff_ctrl.sv
// Sequencer of the PID controller: runs the terms through the shared mul/div unit.
module pidff_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_cmd_i,
  output logic                 in_ready_o,
  input  pidff_pkg::dp_status_t status_i,
  output pidff_pkg::dp_cmd_t    cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_LOAD  = 8'b0000_0010,
    S_MUL   = 8'b0000_0100,
    S_DLOAD = 8'b0000_1000,
    S_DIV   = 8'b0001_0000,
    S_TERM  = 8'b0010_0000,
    S_DONE  = 8'b0100_0000,
    S_CLEAR = 8'b1000_0000
  } state_e;

  state_e                       state_q, state_d;
  pidff_pkg::job_e              job_q, job_d;
  logic [pidff_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic                         need_div;
  logic                         last_job;
  pidff_pkg::job_e              job_next;

  // Derivative terms, and the velocity feed-forward, go through the divider
  assign need_div = (job_q == pidff_pkg::JOB_D) ||
                    ((job_q == pidff_pkg::JOB_FF) && (status_i.mode == pidff_pkg::MODE_VEL));
  assign last_job = (job_q == pidff_pkg::JOB_D);

  always_comb begin
    unique case (job_q)
      pidff_pkg::JOB_IPRE: job_next = pidff_pkg::JOB_P;
      pidff_pkg::JOB_P:    job_next = pidff_pkg::JOB_I;
      pidff_pkg::JOB_I:    job_next = pidff_pkg::JOB_FF;
      pidff_pkg::JOB_FF:   job_next = pidff_pkg::JOB_D;
      default:             job_next = pidff_pkg::JOB_D;
    endcase
  end

  // Next state and command
  always_comb begin
    state_d    = state_q;
    job_d      = job_q;
    cnt_d      = cnt_q;
    cmd_o.op   = pidff_pkg::OP_NOP;
    cmd_o.job  = job_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_cmd_i) begin
            state_d = S_CLEAR;
          end else begin
            cmd_o.op = pidff_pkg::OP_ACCEPT;
            job_d    = pidff_pkg::JOB_IPRE;
            state_d  = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        if (need_div && status_i.dz) begin
          // zero step time: term is zero, skip it
          if (last_job) state_d = S_DONE;
          else          job_d   = job_next;
        end else begin
          cmd_o.op = pidff_pkg::OP_LOAD;
          cnt_d    = '0;
          state_d  = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.op = pidff_pkg::OP_MSTEP;
        if (cnt_q == pidff_pkg::CNT_W'(pidff_pkg::MUL_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = need_div ? S_DLOAD : S_TERM;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_DLOAD: begin
        cmd_o.op = pidff_pkg::OP_DLOAD;
        state_d  = S_DIV;
      end
      S_DIV: begin
        cmd_o.op = pidff_pkg::OP_DSTEP;
        if (cnt_q == pidff_pkg::CNT_W'(pidff_pkg::DIV_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = S_TERM;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_TERM: begin
        cmd_o.op = pidff_pkg::OP_TERM;
        if (last_job) state_d = S_DONE;
        else begin
          job_d   = job_next;
          state_d = S_LOAD;
        end
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.op = pidff_pkg::OP_FINISH;
          state_d  = S_IDLE;
        end
      end
      S_CLEAR: begin
        if (status_i.out_free) begin
          cmd_o.op = pidff_pkg::OP_CLEAR;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      job_q   <= pidff_pkg::JOB_IPRE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      job_q   <= job_d;
      cnt_q   <= cnt_d;
    end
  end

  // Iteration count stays inside the multiply window
  a_mul_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL) |-> (cnt_q < pidff_pkg::CNT_W'(pidff_pkg::MUL_STEPS)))
    else $error("multiply step count out of range");

  // A division always starts from a freshly loaded dividend
  a_div_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_DIV) && !$past(state_q == S_DIV)) |-> $past(state_q == S_DLOAD))
    else $error("division entered without dividend load");

  // Only the derivative-type terms reach the divider
  a_div_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DLOAD) |-> need_div)
    else $error("division started for a term without dt");

endmodule

FILE: src/pidff_datapath.sv
// Datapath: registers, controller state, serial mul/div unit, term sum and output stage.
module pidff_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  pidff_pkg::dp_cmd_t                 cmd_i,
  output pidff_pkg::dp_status_t              status_o,
  input  pidff_pkg::in_t                     in_data_i,
  input  logic                               cfg_valid_i,
  input  logic [pidff_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [pidff_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output pidff_pkg::out_t                    out_data_o
);

  localparam int DATA_W = pidff_pkg::DATA_W;
  localparam int GAIN_W = pidff_pkg::GAIN_W;
  localparam int TIME_W = pidff_pkg::TIME_W;
  localparam int ACC_W  = pidff_pkg::ACC_W;
  localparam int TERM_W = pidff_pkg::TERM_W;
  localparam int ERR_W  = pidff_pkg::ERR_W;
  localparam int OPB_W  = pidff_pkg::OPB_W;
  localparam int MAG_W  = pidff_pkg::MAG_W;
  localparam int PROD_W = pidff_pkg::PROD_W;
  localparam int SUM_W  = pidff_pkg::SUM_W;
  localparam int DVD_W  = pidff_pkg::DVD_W;
  localparam int DVS_W  = pidff_pkg::DVS_W;

  localparam logic [PROD_W-1:0] TERM_LIM = PROD_W'((65'd1 << (TERM_W - 1)) - 65'd1);
  localparam logic signed [SUM_W-1:0] ACC_MAX = SUM_W'((65'sd1 <<< (ACC_W - 1)) - 65'sd1);
  localparam logic signed [SUM_W-1:0] ACC_MIN = -ACC_MAX - SUM_W'(1);
  localparam logic signed [ACC_W-1:0] DAT_MAX = ACC_W'((65'sd1 <<< (DATA_W - 1)) - 65'sd1);
  localparam logic signed [ACC_W-1:0] DAT_MIN = -DAT_MAX - ACC_W'(1);

  // Configuration registers
  pidff_pkg::mode_t         mode_q;
  logic signed [GAIN_W-1:0] gain_p_q, gain_i_q, gain_d_q, gain_ff_q;
  logic signed [DATA_W-1:0] out_min_q, out_max_q;
  logic                     clamp_en_q;

  // Controller state
  logic signed [ERR_W-1:0]  e0_q, e1_q, e2_q;
  logic signed [ACC_W-1:0]  integral_q, accum_q;
  logic signed [DATA_W-1:0] last_sp_q, last_pv_q;

  // Current sample
  logic signed [DATA_W-1:0] sp_q, pv_q;
  logic [TIME_W-1:0]        t_q;
  logic                     dz_q;

  // Mul/div unit and term sum
  logic [PROD_W-1:0]        acc_q;
  logic [MAG_W-1:0]         b_q, pre_q;
  logic [GAIN_W-1:0]        g_q;
  logic                     neg_q, pre_neg_q;
  logic [DVS_W-1:0]         rem_q;
  logic [DVD_W-1:0]         dvd_q;
  logic signed [SUM_W-1:0]  sum_q;
  logic                     flag_q;

  logic                     out_valid_q;
  pidff_pkg::out_t          out_q;

  logic vel, pos, ipd, pid;
  assign vel = (mode_q == pidff_pkg::MODE_VEL);
  assign pos = (mode_q == pidff_pkg::MODE_POS);
  assign pid = (mode_q == pidff_pkg::MODE_PID);
  assign ipd = (mode_q == pidff_pkg::MODE_IPD);

  // Differences of the history
  logic signed [ERR_W:0]   e_d1, e_s1, half;
  logic signed [ERR_W+1:0] e_d2;
  logic signed [ERR_W-1:0] sp_diff, pv_diff, e_new;
  assign e_d1    = (ERR_W+1)'(e0_q) - (ERR_W+1)'(e1_q);
  assign e_d2    = (ERR_W+2)'(e0_q) - ((ERR_W+2)'(e1_q) <<< 1) + (ERR_W+2)'(e2_q);
  assign e_s1    = (ERR_W+1)'(e0_q) + (ERR_W+1)'(e1_q);
  // truncate toward zero on the halving
  assign half    = (e_s1 + $signed({{ERR_W{1'b0}}, e_s1[ERR_W]})) >>> 1;
  assign sp_diff = ERR_W'(sp_q) - ERR_W'(last_sp_q);
  assign pv_diff = ERR_W'(pv_q) - ERR_W'(last_pv_q);
  assign e_new   = ERR_W'(in_data_i.setpoint) - ERR_W'(in_data_i.measured);

  // Operand selection for the current term
  logic signed [OPB_W-1:0]  opb;
  logic signed [GAIN_W-1:0] gsel;
  logic [MAG_W-1:0]         bmag;
  logic                     bneg;
  logic [GAIN_W-1:0]        gmag;
  logic                     gneg;

  always_comb begin
    opb  = '0;
    gsel = '0;
    unique case (cmd_i.job)
      pidff_pkg::JOB_IPRE: opb = vel ? OPB_W'(e0_q) : OPB_W'(half);
      pidff_pkg::JOB_P: begin
        gsel = gain_p_q;
        if (ipd)      opb = OPB_W'(pv_q);
        else if (vel) opb = OPB_W'(e_d1);
        else          opb = OPB_W'(e0_q);
      end
      pidff_pkg::JOB_I: begin
        gsel = gain_i_q;
        opb  = OPB_W'(integral_q);
      end
      pidff_pkg::JOB_FF: begin
        gsel = gain_ff_q;
        opb  = vel ? OPB_W'(sp_diff) : OPB_W'(sp_q);
      end
      pidff_pkg::JOB_D: begin
        gsel = gain_d_q;
        if (vel)      opb = OPB_W'(e_d2);
        else if (pos) opb = OPB_W'(e_d1);
        else          opb = OPB_W'(pv_diff);
      end
      default: opb = '0;
    endcase
  end

  always_comb begin
    if (vel && (cmd_i.job == pidff_pkg::JOB_I)) begin
      bmag = pre_q;
      bneg = pre_neg_q;
    end else begin
      bmag = MAG_W'(opb[OPB_W-1] ? -opb : opb);
      bneg = opb[OPB_W-1];
    end
    if (cmd_i.job == pidff_pkg::JOB_IPRE) begin
      gmag = GAIN_W'(t_q);
      gneg = 1'b0;
    end else begin
      gmag = GAIN_W'(gsel[GAIN_W-1] ? -gsel : gsel);
      gneg = gsel[GAIN_W-1];
    end
  end

  // Divider step
  logic [DVS_W:0] rem_sh, dvs;
  logic           rem_ge;
  assign rem_sh = {rem_q, dvd_q[DVD_W-1]};
  assign dvs    = {1'b0, t_q, {pidff_pkg::FRAC_BITS{1'b0}}};
  assign rem_ge = (rem_sh >= dvs);

  // Term scaling and saturation
  logic                     div_job, flip, over, term_neg;
  logic [PROD_W-1:0]        raw_mag;
  logic [TERM_W-2:0]        tmag;
  logic signed [SUM_W-1:0]  tval, sum_add;
  assign div_job = (cmd_i.job == pidff_pkg::JOB_D) || ((cmd_i.job == pidff_pkg::JOB_FF) && vel);
  assign flip    = ((cmd_i.job == pidff_pkg::JOB_P) && ipd) ||
                   ((cmd_i.job == pidff_pkg::JOB_D) && (pid || ipd));

  always_comb begin
    if (div_job)                           raw_mag = PROD_W'(dvd_q);
    else if (cmd_i.job == pidff_pkg::JOB_I)
      raw_mag = acc_q >> (pidff_pkg::FRAC_BITS + pidff_pkg::TIME_FRAC);
    else                                   raw_mag = acc_q >> pidff_pkg::FRAC_BITS;
  end

  assign over     = (raw_mag > TERM_LIM);
  assign tmag     = over ? '1 : raw_mag[TERM_W-2:0];
  assign term_neg = neg_q ^ flip;
  assign tval     = $signed(SUM_W'(tmag));
  assign sum_add  = term_neg ? (sum_q - tval) : (sum_q + tval);

  // Integral update from the pre-multiply (no flag)
  logic signed [SUM_W-1:0] pval, isum;
  logic signed [ACC_W-1:0] isat;
  assign pval = $signed(SUM_W'(acc_q[MAG_W-1:0]));
  assign isum = SUM_W'(integral_q) + (neg_q ? -pval : pval);
  assign isat = (isum > ACC_MAX) ? ACC_W'(ACC_MAX) :
                ((isum < ACC_MIN) ? ACC_W'(ACC_MIN) : ACC_W'(isum));

  // Final saturation, clamp and output narrowing
  logic signed [ACC_W-1:0]  s48, cx, omin, omax;
  logic signed [DATA_W-1:0] rout;
  logic                     f48, fcl, fdat;
  assign s48  = (sum_q > ACC_MAX) ? ACC_W'(ACC_MAX) :
                ((sum_q < ACC_MIN) ? ACC_W'(ACC_MIN) : ACC_W'(sum_q));
  assign f48  = (SUM_W'(s48) != sum_q);
  assign omin = ACC_W'(out_min_q);
  assign omax = ACC_W'(out_max_q);
  assign cx   = !clamp_en_q ? s48 :
                ((s48 > omax) ? omax : ((omin > s48) ? omin : s48));
  assign fcl  = (cx != s48);
  assign rout = (cx > DAT_MAX) ? DATA_W'(DAT_MAX) :
                ((cx < DAT_MIN) ? DATA_W'(DAT_MIN) : DATA_W'(cx));
  assign fdat = (ACC_W'(rout) != cx);

  // Registers and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= pidff_pkg::MODE_POS;
      gain_p_q    <= '0;
      gain_i_q    <= '0;
      gain_d_q    <= '0;
      gain_ff_q   <= '0;
      out_min_q   <= {1'b1, {(DATA_W-1){1'b0}}};
      out_max_q   <= {1'b0, {(DATA_W-1){1'b1}}};
      clamp_en_q  <= 1'b0;
      e0_q        <= '0;
      e1_q        <= '0;
      e2_q        <= '0;
      integral_q  <= '0;
      accum_q     <= '0;
      last_sp_q   <= '0;
      last_pv_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          pidff_pkg::REG_MODE:    mode_q     <= cfg_data_i[1:0];
          pidff_pkg::REG_GAIN_P:  gain_p_q   <= cfg_data_i;
          pidff_pkg::REG_GAIN_I:  gain_i_q   <= cfg_data_i;
          pidff_pkg::REG_GAIN_D:  gain_d_q   <= cfg_data_i;
          pidff_pkg::REG_GAIN_FF: gain_ff_q  <= cfg_data_i;
          pidff_pkg::REG_OUT_MIN: out_min_q  <= cfg_data_i;
          pidff_pkg::REG_OUT_MAX: out_max_q  <= cfg_data_i;
          pidff_pkg::REG_CLAMP:   clamp_en_q <= cfg_data_i[0];
        endcase
      end
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (cmd_i.op)
        pidff_pkg::OP_ACCEPT: begin
          e2_q <= e1_q;
          e1_q <= e0_q;
          e0_q <= e_new;
        end
        pidff_pkg::OP_TERM: begin
          if ((cmd_i.job == pidff_pkg::JOB_IPRE) && !vel) integral_q <= isat;
        end
        pidff_pkg::OP_FINISH: begin
          accum_q     <= vel ? s48 : cx;
          if (vel)        last_sp_q <= sp_q;
          if (pid || ipd) last_pv_q <= pv_q;
          out_valid_q <= 1'b1;
        end
        pidff_pkg::OP_CLEAR: begin
          e0_q        <= '0;
          e1_q        <= '0;
          e2_q        <= '0;
          integral_q  <= '0;
          accum_q     <= '0;
          last_sp_q   <= '0;
          last_pv_q   <= '0;
          out_valid_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Working registers, no reset
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      pidff_pkg::OP_ACCEPT: begin
        sp_q   <= in_data_i.setpoint;
        pv_q   <= in_data_i.measured;
        t_q    <= in_data_i.step_time;
        dz_q   <= (in_data_i.step_time == '0);
        sum_q  <= vel ? SUM_W'(accum_q) : '0;
        flag_q <= 1'b0;
      end
      pidff_pkg::OP_LOAD: begin
        acc_q <= '0;
        b_q   <= bmag;
        g_q   <= gmag;
        neg_q <= bneg ^ gneg;
      end
      pidff_pkg::OP_MSTEP: begin
        // MSB-first shift and add
        acc_q <= (acc_q << 1) + (g_q[GAIN_W-1] ? PROD_W'(b_q) : '0);
        g_q   <= g_q << 1;
      end
      pidff_pkg::OP_DLOAD: begin
        dvd_q <= DVD_W'(acc_q) << pidff_pkg::TIME_FRAC;
        rem_q <= '0;
      end
      pidff_pkg::OP_DSTEP: begin
        // restoring division, one quotient bit per cycle
        rem_q <= rem_ge ? DVS_W'(rem_sh - dvs) : DVS_W'(rem_sh);
        dvd_q <= {dvd_q[DVD_W-2:0], rem_ge};
      end
      pidff_pkg::OP_TERM: begin
        if (cmd_i.job == pidff_pkg::JOB_IPRE) begin
          pre_q     <= acc_q[MAG_W-1:0];
          pre_neg_q <= neg_q;
        end else begin
          sum_q  <= sum_add;
          flag_q <= flag_q | over;
        end
      end
      pidff_pkg::OP_FINISH: begin
        out_q.drive   <= rout;
        out_q.clamped <= flag_q | f48 | fcl | fdat;
        out_q.dt_zero <= dz_q;
      end
      pidff_pkg::OP_CLEAR: out_q <= '0;
      default: ;
    endcase
  end

  assign status_o.mode     = mode_q;
  assign status_o.dz       = dz_q;
  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;

  // A result is written only into a free output register
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cmd_i.op == pidff_pkg::OP_FINISH) || (cmd_i.op == pidff_pkg::OP_CLEAR)) |->
      (!out_valid_q || out_ready_i))
    else $error("result written over an untaken result");

  // Output valid comes only from a finish or a clear
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |->
      $past((cmd_i.op == pidff_pkg::OP_FINISH) || (cmd_i.op == pidff_pkg::OP_CLEAR)))
    else $error("output valid without a finished transaction");

endmodule

FILE: src/pid_controller_four_forms.sv
// Top level of the four-form PID controller with feed-forward.
//
// One transaction on the input channel is one control sample; each gives exactly one
// result transaction. A compute sample is accepted, then runs five terms on a
// shared serial multiplier (one bit of the 32-bit gain per cycle, with load and
// accumulate), and each derivative-type term then also runs on the
// restoring divider (the derivative, and in velocity form also the feed-forward);
// then a finish step writes the result. When the step time is zero the divided terms
// are skipped. The next sample is accepted while the previous result still waits
// in the output register. Configuration writes are always accepted and must be
// made while idle.
module pid_controller_four_forms (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  pidff_pkg::in_t                   in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output pidff_pkg::out_t                  out_data_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [pidff_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pidff_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  pidff_pkg::dp_cmd_t    dp_cmd;
  pidff_pkg::dp_status_t dp_status;

  assign cfg_ready_o = 1'b1;

  // Sequencer
  pidff_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_cmd_i   (in_data_i.cmd),
    .in_ready_o (in_ready_o),
    .status_i   (dp_status),
    .cmd_o      (dp_cmd)
  );

  // Arithmetic and state
  pidff_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .status_o    (dp_status),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
